>>> hdl/wfh_pkg.sv
package wfh_pkg;

  localparam int REG_SLOTS          = 4;
  localparam int WEIGHT_W           = 8;
  localparam int TOTAL_W            = 10;
  localparam int HASH_W             = 32;
  localparam int ADDR_W             = 4;
  localparam int HASH_STAGES        = 8;
  localparam int MOD_BITS_PER_STAGE = 4;
  localparam int MOD_STAGES         = HASH_W / MOD_BITS_PER_STAGE;

  localparam logic [HASH_W-1:0] HASH_OFFSET    = 32'h811C_9DC5;
  localparam logic [15:0]       MIN_FRAME      = 16'd34;
  localparam logic [15:0]       ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0]       ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]        IP_VERSION     = 4'd4;
  localparam logic [7:0]        PROTO_REQUIRED = 8'd89;
  localparam logic [5:0]        MIN_IHL_BYTES  = 6'd20;

  typedef enum logic [1:0] {
    REG_COUNT   = 2'd0,
    REG_ENABLE  = 2'd1,
    REG_WEIGHTS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CHOSEN  = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_PATH = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  version_and_header_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } in_data_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] interface_index;
  } out_data_t;

  typedef struct packed {
    logic [REG_SLOTS-1:0]          enabled;
    logic [REG_SLOTS-1:0]          usable;
    logic [REG_SLOTS*WEIGHT_W-1:0] weights;
    logic [TOTAL_W-1:0]            total;
  } cfg_view_t;

  // fnv prime 2^24 + 403 as shift-add
  function automatic logic [HASH_W-1:0] fnv_step(logic [HASH_W-1:0] h, logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic frame_ok(in_data_t d);
    logic [5:0]  ihl;
    logic [15:0] need;
    ihl  = {d.version_and_header_length[3:0], 2'b00};
    need = ETH_HDR_BYTES + {10'd0, ihl};
    return (d.frame_length >= MIN_FRAME) && (d.ether_type == ETHERTYPE_IPV4) &&
           (d.version_and_header_length[7:4] == IP_VERSION) &&
           (d.ip_protocol == PROTO_REQUIRED) && (ihl >= MIN_IHL_BYTES) &&
           (d.frame_length >= need);
  endfunction

endpackage

>>> hdl/wfh_cfg.sv
module wfh_cfg #(
  parameter int INTERFACE_SLOTS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wfh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output wfh_pkg::cfg_view_t         view
);

  logic [2:0]  count_r;
  logic [3:0]  enable_r;
  logic [31:0] weights_r;
  wfh_pkg::reg_idx_t idx;
  logic [wfh_pkg::REG_SLOTS-1:0] in_range;

  assign idx = wfh_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      enable_r  <= '0;
      weights_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        wfh_pkg::REG_COUNT:   count_r   <= pwdata[2:0];
        wfh_pkg::REG_ENABLE:  enable_r  <= pwdata[3:0];
        wfh_pkg::REG_WEIGHTS: weights_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wfh_pkg::REG_COUNT:   prdata = {29'd0, count_r};
      wfh_pkg::REG_ENABLE:  prdata = {28'd0, enable_r};
      wfh_pkg::REG_WEIGHTS: prdata = weights_r;
      default:              prdata = '0;
    endcase
  end

  for (genvar i = 0; i < wfh_pkg::REG_SLOTS; i++) begin : g_slot
    if (i < INTERFACE_SLOTS) begin : g_in
      assign in_range[i] = 3'(i) < count_r;
    end else begin : g_out
      assign in_range[i] = 1'b0;
    end
  end

  always_comb begin
    view.enabled = enable_r & in_range;
    view.weights = weights_r;
    view.total   = '0;
    for (int i = 0; i < wfh_pkg::REG_SLOTS; i++) begin
      view.usable[i] = view.enabled[i] && (weights_r[8*i +: 8] != 8'd0);
      if (view.usable[i]) begin
        view.total = view.total + {2'd0, weights_r[8*i +: 8]};
      end
    end
  end

endmodule

>>> hdl/wfh_hash.sv
module wfh_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  wfh_pkg::in_data_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ok,
  output logic [wfh_pkg::HASH_W-1:0] hash
);

  localparam int N = wfh_pkg::HASH_STAGES;

  logic [N-1:0] vld_r;
  logic [N:0]   rdy;
  logic [N-1:0] vin;
  logic [N-1:0] ok_r;
  logic [N-1:0] okin;
  logic [wfh_pkg::HASH_W-1:0] hash_r  [N];
  logic [wfh_pkg::HASH_W-1:0] hin     [N];
  logic [wfh_pkg::HASH_W-1:0] hash_nxt[N];
  logic [63:0]                addr_r  [N];
  logic [63:0]                ain     [N];

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign vin[k]  = in_valid;
      assign okin[k] = wfh_pkg::frame_ok(in_data);
      assign hin[k]  = wfh_pkg::HASH_OFFSET;
      assign ain[k]  = {in_data.source_address, in_data.destination_address};
    end else begin : g_next
      assign vin[k]  = vld_r[k-1];
      assign okin[k] = ok_r[k-1];
      assign hin[k]  = hash_r[k-1];
      assign ain[k]  = addr_r[k-1];
    end

    assign rdy[k]      = !vld_r[k] || rdy[k+1];
    assign hash_nxt[k] = wfh_pkg::fnv_step(hin[k], ain[k][63-8*k -: 8]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin[k]) begin
        ok_r[k]   <= okin[k];
        hash_r[k] <= hash_nxt[k];
        addr_r[k] <= ain[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[N-1];
  assign ok        = ok_r[N-1];
  assign hash      = hash_r[N-1];

endmodule

>>> hdl/wfh_mod.sv
module wfh_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_ok,
  input  logic [wfh_pkg::HASH_W-1:0]  in_hash,
  input  logic [wfh_pkg::TOTAL_W-1:0] total,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [wfh_pkg::TOTAL_W-1:0] rem
);

  localparam int N = wfh_pkg::MOD_STAGES;
  localparam int B = wfh_pkg::MOD_BITS_PER_STAGE;
  localparam int W = wfh_pkg::TOTAL_W;

  logic [N-1:0] vld_r;
  logic [N:0]   rdy;
  logic [N-1:0] vin;
  logic [N-1:0] ok_r;
  logic [N-1:0] okin;
  logic [wfh_pkg::HASH_W-1:0] hash_r [N];
  logic [wfh_pkg::HASH_W-1:0] hin    [N];
  logic [W-1:0]               rem_r  [N];
  logic [W-1:0]               rin    [N];
  logic [W-1:0]               rem_nxt[N];

  // restoring remainder, one hash bit per step
  function automatic logic [W-1:0] rem_steps(logic [W-1:0] r, logic [B-1:0] bits,
                                             logic [W-1:0] d);
    logic [W:0]   t;
    logic [W-1:0] acc;
    acc = r;
    for (int j = B - 1; j >= 0; j--) begin
      t = {acc, bits[j]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[W-1:0];
    end
    return acc;
  endfunction

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign vin[k]  = in_valid;
      assign okin[k] = in_ok;
      assign hin[k]  = in_hash;
      assign rin[k]  = '0;
    end else begin : g_next
      assign vin[k]  = vld_r[k-1];
      assign okin[k] = ok_r[k-1];
      assign hin[k]  = hash_r[k-1];
      assign rin[k]  = rem_r[k-1];
    end

    assign rdy[k]     = !vld_r[k] || rdy[k+1];
    assign rem_nxt[k] = rem_steps(rin[k], hin[k][wfh_pkg::HASH_W-1-B*k -: B], total);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin[k]) begin
        ok_r[k]   <= okin[k];
        hash_r[k] <= hin[k];
        rem_r[k]  <= rem_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[N-1];
  assign ok        = ok_r[N-1];
  assign rem       = rem_r[N-1];

  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N-1] && total != '0 |-> rem_r[N-1] < total)
    else $error("remainder not below weight total");

  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N-1] && !out_ready |=> vld_r[N-1] && $stable(rem_r[N-1]) && $stable(ok_r[N-1]))
    else $error("stalled remainder changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(vld_r[N-1]) |-> $past(out_ready))
    else $error("remainder dropped without transfer");

endmodule

>>> hdl/wfh_pick.sv
module wfh_pick (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_ok,
  input  logic [wfh_pkg::TOTAL_W-1:0] in_rem,
  input  wfh_pkg::cfg_view_t          view,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wfh_pkg::out_data_t          out_data
);

  logic               out_valid_r;
  wfh_pkg::out_data_t out_data_r;
  wfh_pkg::out_data_t out_data_nxt;
  logic [wfh_pkg::TOTAL_W-1:0] cum;
  logic                        found;

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    out_data_nxt.status          = wfh_pkg::ST_NO_PATH;
    out_data_nxt.interface_index = 2'd0;
    cum   = '0;
    found = 1'b0;
    if (!in_ok) begin
      out_data_nxt.status = wfh_pkg::ST_INVALID;
    end else if (view.total == '0) begin
      for (int i = wfh_pkg::REG_SLOTS - 1; i >= 0; i--) begin
        if (view.enabled[i]) begin
          out_data_nxt.status          = wfh_pkg::ST_CHOSEN;
          out_data_nxt.interface_index = 2'(i);
        end
      end
    end else begin
      for (int i = 0; i < wfh_pkg::REG_SLOTS; i++) begin
        if (view.usable[i]) begin
          cum = cum + {2'd0, view.weights[8*i +: 8]};
          if (!found && in_rem < cum) begin
            found                        = 1'b1;
            out_data_nxt.status          = wfh_pkg::ST_CHOSEN;
            out_data_nxt.interface_index = 2'(i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != wfh_pkg::ST_CHOSEN |->
      out_data_r.interface_index == 2'd0)
    else $error("index set without a chosen interface");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == wfh_pkg::ST_CHOSEN |->
      view.enabled[out_data_r.interface_index])
    else $error("chosen interface not enabled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == wfh_pkg::ST_NO_PATH |-> view.total == '0)
    else $error("no path reported with nonzero weight total");

endmodule

>>> hdl/weighted_flow_hash_path_select.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+----------------------------------
// in        | in_valid / in_ready           | in_data (wfh_pkg::in_data_t)
// out       | out_valid / out_ready         | out_data (wfh_pkg::out_data_t)
// cfg       | cfg_psel / cfg_penable, write | cfg_paddr, cfg_pwdata, cfg_prdata
//
// one transfer per cycle sustained while out_ready stays high; path from input to output
// register: 8 hash stages (one fnv byte each), 8 remainder stages (4 bits each),
// one select stage
// synchronous active-low reset clears valid bits and config registers
// a stall fills bubbles upstream first; in_ready drops only when every stage holds data
module weighted_flow_hash_path_select #(
  parameter int INTERFACE_SLOTS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  wfh_pkg::in_data_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output wfh_pkg::out_data_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [wfh_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  wfh_pkg::cfg_view_t          view;
  logic                        h_valid;
  logic                        h_ready;
  logic                        h_ok;
  logic [wfh_pkg::HASH_W-1:0]  h_hash;
  logic                        m_valid;
  logic                        m_ready;
  logic                        m_ok;
  logic [wfh_pkg::TOTAL_W-1:0] m_rem;

  assign cfg_pready = 1'b1;

  wfh_cfg #(
    .INTERFACE_SLOTS(INTERFACE_SLOTS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .view   (view)
  );

  wfh_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(h_valid),
    .out_ready(h_ready),
    .ok       (h_ok),
    .hash     (h_hash)
  );

  wfh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (h_valid),
    .in_ready (h_ready),
    .in_ok    (h_ok),
    .in_hash  (h_hash),
    .total    (view.total),
    .out_valid(m_valid),
    .out_ready(m_ready),
    .ok       (m_ok),
    .rem      (m_rem)
  );

  wfh_pick u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (m_valid),
    .in_ready (m_ready),
    .in_ok    (m_ok),
    .in_rem   (m_rem),
    .view     (view),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
